// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on a clock and held off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assertion sampled on a clock that also checks during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: rtl/scd_pkg.sv
// Package with widths, latencies and the reset value of the scalar dissipation stencil.
`timescale 1ns / 1ps
package scd_pkg;
    localparam int ScalarBits   = 16;
    localparam int SpacingBits  = 24;
    localparam int ViscBits     = 32;
    localparam int PrBits       = 16;
    localparam int ProdBits     = ViscBits + PrBits;
    localparam int ResultBits   = 48;
    localparam int GradBits     = 31;
    localparam int SqBits       = 2 * GradBits;
    localparam int SumBits      = 64;
    localparam int DivNumBits   = 32;
    localparam int DivStepBits  = 4;
    localparam int DivStages    = DivNumBits / DivStepBits;
    localparam int MacLatency   = 6;
    localparam int Latency      = 1 + DivStages + MacLatency;
    localparam int InDataBits   = 6 * ScalarBits + 3 * SpacingBits + ViscBits;
    localparam int InTdataBits  = ((InDataBits + 7) / 8) * 8;
    localparam int OutTdataBits = ((ResultBits + 7) / 8) * 8;
    localparam logic [PrBits-1:0] PrReset = PrBits'(10240);

    typedef logic [GradBits-1:0] t_grad;
endpackage

// File: rtl/scd_div.sv
// Pipelined restoring divider that gives the gradient magnitude of one axis.
`timescale 1ns / 1ps
module scd_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [scd_pkg::DivNumBits-1:0]      i_num,
    input  logic [scd_pkg::SpacingBits-1:0]     i_den,
    output logic [scd_pkg::DivNumBits-1:0]      o_quo
);
    localparam int NB = scd_pkg::DivNumBits;
    localparam int WB = scd_pkg::SpacingBits;

    logic [WB-1:0] r_rem [scd_pkg::DivStages];
    logic [NB-1:0] r_nq  [scd_pkg::DivStages];
    logic [WB-1:0] r_den [scd_pkg::DivStages];

    function automatic logic [WB+NB-1:0] div_steps(logic [WB-1:0] rem,
                                                    logic [NB-1:0] nq,
                                                    logic [WB-1:0] den);
        logic [WB:0]   wide;
        logic [WB-1:0] r;
        logic [NB-1:0] q;
        r = rem;
        q = nq;
        for (int k = 0; k < scd_pkg::DivStepBits; k++) begin
            wide = {r, q[NB-1]};
            q    = {q[NB-2:0], 1'b0};
            if (wide >= {1'b0, den}) begin
                wide = wide - {1'b0, den};
                q[0] = 1'b1;
            end
            r = wide[WB-1:0];
        end
        return {r, q};
    endfunction

    for (genvar s = 0; s < scd_pkg::DivStages; s++) begin : g_stage
        logic [WB-1:0] n_rem;
        logic [NB-1:0] n_nq;
        if (s == 0) begin : g_first
            assign {n_rem, n_nq} = div_steps('0, i_num, i_den);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_nq[s]  <= n_nq;
                    r_den[s] <= i_den;
                end
            end
        end else begin : g_next
            assign {n_rem, n_nq} = div_steps(r_rem[s-1], r_nq[s-1], r_den[s-1]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_nq[s]  <= n_nq;
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    assign o_quo = r_nq[scd_pkg::DivStages-1];
endmodule

// File: rtl/scd_mac.sv
// Squares, sum, wide product with viscosity and saturation of the result.
`timescale 1ns / 1ps
module scd_mac (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  scd_pkg::t_grad                     i_gx,
    input  scd_pkg::t_grad                     i_gy,
    input  scd_pkg::t_grad                     i_gz,
    input  logic [scd_pkg::ProdBits-1:0]       i_prod,
    input  logic                               i_zero,
    output logic [scd_pkg::ResultBits-1:0]     o_dissip,
    output logic                               o_sat
);
    localparam int PB = scd_pkg::ProdBits;
    localparam int SQ = scd_pkg::SqBits;
    localparam int SB = scd_pkg::SumBits;
    localparam int RB = scd_pkg::ResultBits;

    logic [SQ-1:0]  r_sqx, r_sqy, r_sqz;
    logic [PB-1:0]  r_p1, r_p2;
    logic [4:0]     r_z;
    logic [SB-1:0]  r_sum;
    logic [63:0]    r_p00, r_p01;
    logic [47:0]    r_p10, r_p11;
    logic [95:0]    r_t0;
    logic [79:0]    r_t1;
    logic [111:0]   r_tot;
    logic [RB-1:0]  r_dissip;
    logic           r_sat;
    logic           n_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= i_gx * i_gx;
            r_sqy <= i_gy * i_gy;
            r_sqz <= i_gz * i_gz;
            r_p1  <= i_prod;
            r_z   <= {r_z[3:0], i_zero};
            r_sum <= SB'(r_sqx) + SB'(r_sqy) + SB'(r_sqz);
            r_p2  <= r_p1;
            r_p00 <= r_p2[31:0] * r_sum[31:0];
            r_p01 <= r_p2[31:0] * r_sum[63:32];
            r_p10 <= r_p2[PB-1:32] * r_sum[31:0];
            r_p11 <= r_p2[PB-1:32] * r_sum[63:32];
            r_t0  <= 96'(r_p00) + {r_p01, 32'd0};
            r_t1  <= 80'(r_p10) + {r_p11, 32'd0};
            r_tot <= 112'(r_t0) + {r_t1, 32'd0};
            r_sat <= n_sat;
            r_dissip <= n_sat ? {RB{1'b1}} : r_tot[91:44];
        end
    end

    assign n_sat    = r_z[4] | (|r_tot[111:92]);
    assign o_dissip = r_dissip;
    assign o_sat    = r_sat;
endmodule

// File: rtl/scalar_dissipation_stencil.sv
// Top level of the scalar dissipation stencil pipeline.
//   channel  | direction | signals
//   s_axis   | in        | tvalid, tready, tdata (cell neighbours, widths, viscosity)
//   m_axis   | out       | tvalid, tready, tdata (dissipation), tuser (saturated)
//   cfg      | in        | i_cfg_we, i_cfg_wdata (reciprocal turbulent Prandtl number)
// One item per cycle enters while the pipeline is not held; each item passes 15 register
// stages (one input stage, eight divider stages and six multiply and saturate stages)
// before its result shows on m_axis.
// The whole pipeline advances together and holds while a result waits for m_axis_tready.
// Reset is synchronous, clears the valid bits and loads the Prandtl register with its reset value.
`timescale 1ns / 1ps
module scalar_dissipation_stencil (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scd_pkg::PrBits-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // east, west, north, south, top, bottom, spacing_x, spacing_y, spacing_z, eddy_viscosity
    input  logic [scd_pkg::InTdataBits-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dissipation
    output logic [scd_pkg::OutTdataBits-1:0]    m_axis_tdata,
    // saturated
    output logic [0:0]                          m_axis_tuser
);
    localparam int SB = scd_pkg::ScalarBits;
    localparam int WB = scd_pkg::SpacingBits;
    localparam int NB = scd_pkg::DivNumBits;
    localparam int LS = scd_pkg::GradBits - SB;
    localparam int OW = 6 * SB;

    logic [scd_pkg::PrBits-1:0]   r_pr;
    logic [scd_pkg::Latency-1:0]  r_vld;
    logic                         en;
    logic [SB-1:0]  se, sw, sn, ss, st, sb;
    logic [WB-1:0]  wx, wy, wz;
    logic [scd_pkg::ViscBits-1:0] visc;
    logic [NB-1:0]  r_nx, r_ny, r_nz;
    logic [WB-1:0]  r_wx, r_wy, r_wz;
    logic [scd_pkg::ProdBits-1:0] r_prod [scd_pkg::DivStages+1];
    logic           r_zero [scd_pkg::DivStages+1];
    logic [NB-1:0]  qx, qy, qz;
    logic [scd_pkg::ResultBits-1:0] dissip;
    logic           sat;

    assign se   = s_axis_tdata[SB-1:0];
    assign sw   = s_axis_tdata[2*SB-1:SB];
    assign sn   = s_axis_tdata[3*SB-1:2*SB];
    assign ss   = s_axis_tdata[4*SB-1:3*SB];
    assign st   = s_axis_tdata[5*SB-1:4*SB];
    assign sb   = s_axis_tdata[6*SB-1:5*SB];
    assign wx   = s_axis_tdata[OW+WB-1:OW];
    assign wy   = s_axis_tdata[OW+2*WB-1:OW+WB];
    assign wz   = s_axis_tdata[OW+3*WB-1:OW+2*WB];
    assign visc = s_axis_tdata[OW+3*WB+scd_pkg::ViscBits-1:OW+3*WB];

    assign en            = !r_vld[scd_pkg::Latency-1] || m_axis_tready;
    assign s_axis_tready = en;

    function automatic logic [NB-1:0] grad_num(logic [SB-1:0] a, logic [SB-1:0] b);
        logic [SB-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return NB'({d, {LS{1'b0}}});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr  <= scd_pkg::PrReset;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pr <= i_cfg_wdata;
            end
            if (en) begin
                r_vld <= {r_vld[scd_pkg::Latency-2:0], s_axis_tvalid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx      <= grad_num(se, sw);
            r_ny      <= grad_num(sn, ss);
            r_nz      <= grad_num(st, sb);
            r_wx      <= wx;
            r_wy      <= wy;
            r_wz      <= wz;
            r_prod[0] <= visc * r_pr;
            r_zero[0] <= (wx == '0) || (wy == '0) || (wz == '0);
            for (int k = 1; k <= scd_pkg::DivStages; k++) begin
                r_prod[k] <= r_prod[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    scd_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_nx), .i_den(r_wx), .o_quo(qx));
    scd_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_ny), .i_den(r_wy), .o_quo(qy));
    scd_div u_div_z (.i_clk(i_clk), .i_en(en), .i_num(r_nz), .i_den(r_wz), .o_quo(qz));

    scd_mac u_mac (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_gx     (qx[scd_pkg::GradBits-1:0]),
        .i_gy     (qy[scd_pkg::GradBits-1:0]),
        .i_gz     (qz[scd_pkg::GradBits-1:0]),
        .i_prod   (r_prod[scd_pkg::DivStages]),
        .i_zero   (r_zero[scd_pkg::DivStages]),
        .o_dissip (dissip),
        .o_sat    (sat)
    );

    assign m_axis_tvalid = r_vld[scd_pkg::Latency-1];
    assign m_axis_tdata  = scd_pkg::OutTdataBits'(dissip);
    assign m_axis_tuser  = sat;
endmodule

// File: rtl/scd_chk.sv
// Port-level checker for the scalar dissipation stencil and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `ASSERT_CLK(a_ready_rule, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `ASSERT_CLK(a_sat_max, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> (&m_axis_tdata))
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
endmodule

bind scalar_dissipation_stencil scd_chk u_scd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
